@@ src/rtcc_pkg.sv @@
package rtcc_pkg;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_RECEIVE_WINDOW     = 4'd0,
        REG_INITIAL_SSTHRESH   = 4'd1,
        REG_AVOIDANCE_SSTHRESH = 4'd2,
        REG_INITIAL_SRTT       = 4'd3,
        REG_INITIAL_TIMEOUT    = 4'd4,
        REG_TIMEOUT_CAP        = 4'd5,
        REG_FALLBACK_TIMEOUT   = 4'd6,
        REG_INITIAL_SEND_BASE  = 4'd7
    } rtcc_reg_idx_t;

    // Event kinds carried in req_type.
    localparam logic REQ_ACK     = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // Register defaults after reset.
    localparam logic [15:0] RST_RECEIVE_WINDOW     = 16'd65535;
    localparam logic [15:0] RST_INITIAL_SSTHRESH   = 16'd128;
    localparam logic [15:0] RST_AVOIDANCE_SSTHRESH = 16'd64;
    localparam logic [23:0] RST_INITIAL_SRTT       = 24'd20000;
    localparam logic [23:0] RST_INITIAL_TIMEOUT    = 24'd30000;
    localparam logic [23:0] RST_TIMEOUT_CAP        = 24'd1000000;
    localparam logic [23:0] RST_FALLBACK_TIMEOUT   = 24'd15000;
    localparam logic [31:0] RST_INITIAL_SEND_BASE  = 32'd0;

    localparam logic [15:0] CWND_MAX = 16'hFFFF;

    typedef struct packed {
        logic        req_type;
        logic        ack_flag;
        logic [31:0] ack_seq;
        logic        rtt_valid;
        logic [23:0] rtt_sample_us;
        logic        window_drained;
    } rtcc_in_t;

    typedef struct packed {
        logic [15:0] window_limit;
        logic [15:0] cwnd_value;
        logic [15:0] ssthresh_value;
        logic        slow_start_on;
        logic        cong_avoid_on;
        logic        fast_recovery_on;
        logic [23:0] timeout_us;
        logic        fast_retransmit;
        logic [31:0] retransmit_seq;
        logic        resend_unacked;
    } rtcc_out_t;

endpackage

@@ src/reliable_transport_congestion_control_unit.sv @@
// Channel   Direction  Payload      Transfer when
// in        input      rtcc_in_t    in_valid && in_ready
// out       output     rtcc_out_t   out_valid && out_ready
// cfg       input      index, data  cfg_valid && cfg_ready (always ready)
//
// An event is captured in an input register and resolved combinationally into the
// result register, so one event per cycle is sustained while the output is taken.
// The path that sets the clock is the RTT update: difference, smoothing add,
// deviation sum and the timeout compare against the cap.
// Reset loads the configuration registers with their defaults and the state with its initial values.
// A stalled output holds its result; the input register still takes one more event.
module reliable_transport_congestion_control_unit
    import rtcc_pkg::*;
#(
    parameter int DUP_ACK_LIMIT = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rtcc_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rtcc_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers. The initial-value registers only load state
    // when written, so they need no storage of their own.
    logic [15:0] recv_win_reg;
    logic [15:0] avoid_ssth_reg;
    logic [23:0] rto_cap_reg;
    logic [23:0] fallback_rto_reg;

    // Connection state.
    logic [31:0] send_base_reg, send_base_next;
    logic [1:0]  dup_count_reg, dup_count_next;
    logic [15:0] cwnd_reg, cwnd_next;
    logic [15:0] ssthresh_reg, ssthresh_next;
    logic        slow_reg, slow_next;
    logic        avoid_reg, avoid_next;
    logic        recov_reg, recov_next;
    logic [23:0] srtt_reg, srtt_next;
    logic [23:0] rtt_dev_reg, rtt_dev_next;
    logic [23:0] rto_reg, rto_next;

    // Pipeline registers.
    rtcc_in_t    in_reg;
    logic        in_vld_reg;
    rtcc_out_t   out_reg, out_next;
    logic        out_vld_reg;
    logic        advance;

    logic               cfg_write;
    logic        [1:0]  dup_inc;
    logic signed [24:0] rtt_diff;
    logic signed [24:0] rtt_step;
    logic signed [24:0] srtt_sum;
    logic        [23:0] srtt_new;
    logic signed [24:0] gap_signed;
    logic        [23:0] rtt_gap;
    logic        [25:0] dev_sum;
    logic        [23:0] dev_new;
    logic        [26:0] rto_sum;
    logic        [23:0] rto_new;

    // Handshake: the event moves to the result register when that one is free or its result is taken.
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    // RTT smoothing: srtt moves one eighth toward the sample (floor division),
    // the deviation keeps three quarters of its old value.
    assign rtt_diff   = $signed({1'b0, in_reg.rtt_sample_us}) - $signed({1'b0, srtt_reg});
    assign rtt_step   = rtt_diff >>> 3;
    assign srtt_sum   = $signed({1'b0, srtt_reg}) + rtt_step;
    assign srtt_new   = srtt_sum[23:0];
    assign gap_signed = $signed({1'b0, srtt_new}) - $signed({1'b0, in_reg.rtt_sample_us});
    assign rtt_gap    = gap_signed[24] ? 24'(-gap_signed) : gap_signed[23:0];
    assign dev_sum    = {1'b0, rtt_dev_reg, 1'b0} + {2'b00, rtt_dev_reg} + {2'b00, rtt_gap};
    assign dev_new    = dev_sum[25:2];
    assign rto_sum    = {3'b000, srtt_new} + {1'b0, dev_new, 2'b00};
    assign rto_new    = (rto_sum > {3'b000, rto_cap_reg}) ? fallback_rto_reg : rto_sum[23:0];

    assign dup_inc = dup_count_reg + 2'd1;

    // Window and phase update for the event in the input register.
    always_comb
    begin
        send_base_next = send_base_reg;
        dup_count_next = dup_count_reg;
        cwnd_next      = cwnd_reg;
        ssthresh_next  = ssthresh_reg;
        slow_next      = slow_reg;
        avoid_next     = avoid_reg;
        recov_next     = recov_reg;
        srtt_next      = srtt_reg;
        rtt_dev_next   = rtt_dev_reg;
        rto_next       = rto_reg;
        out_next       = '0;

        if (in_reg.req_type == REQ_ACK)
        begin
            if (in_reg.ack_flag)
            begin
                if (in_reg.ack_seq == send_base_reg)
                begin
                    // Duplicate acknowledgement.
                    dup_count_next = dup_inc;
                    if (dup_inc == 2'(DUP_ACK_LIMIT))
                    begin
                        out_next.fast_retransmit = 1'b1;
                        out_next.retransmit_seq  = in_reg.ack_seq;
                        dup_count_next           = 2'd0;
                        if (cwnd_next > 16'd1)
                        begin
                            cwnd_next = cwnd_next >> 1;
                        end
                        ssthresh_next = cwnd_next;
                        recov_next    = 1'b1;
                    end
                end
                else if (in_reg.ack_seq > send_base_reg)
                begin
                    // New data acknowledged; leaving fast recovery grows the window by one.
                    if (recov_reg)
                    begin
                        if (cwnd_next != CWND_MAX)
                        begin
                            cwnd_next = cwnd_next + 16'd1;
                        end
                        recov_next = 1'b0;
                        avoid_next = 1'b1;
                        slow_next  = 1'b0;
                    end
                    dup_count_next = 2'd0;
                    send_base_next = in_reg.ack_seq;
                    if (in_reg.rtt_valid)
                    begin
                        srtt_next    = srtt_new;
                        rtt_dev_next = dev_new;
                        rto_next     = rto_new;
                    end
                end
            end

            // Threshold reached: enter congestion avoidance, restart the window at one, load the avoidance threshold.
            if (cwnd_next >= ssthresh_next)
            begin
                avoid_next    = 1'b1;
                slow_next     = 1'b0;
                cwnd_next     = 16'd1;
                ssthresh_next = avoid_ssth_reg;
            end

            // Drained window: double in slow start, otherwise add one.
            if (in_reg.window_drained)
            begin
                if (slow_next)
                begin
                    cwnd_next = cwnd_next[15] ? CWND_MAX : {cwnd_next[14:0], 1'b0};
                end
                else if (cwnd_next != CWND_MAX)
                begin
                    cwnd_next = cwnd_next + 16'd1;
                end
            end
        end
        else
        begin
            // Retransmit timer expired.
            ssthresh_next = (cwnd_reg > 16'd1) ? (cwnd_reg >> 1) : 16'd1;
            cwnd_next     = 16'd1;
            recov_next    = 1'b0;
            slow_next     = 1'b1;
            avoid_next    = 1'b0;
            out_next.resend_unacked = 1'b1;
        end

        out_next.window_limit     = (recv_win_reg < cwnd_next) ? recv_win_reg : cwnd_next;
        out_next.cwnd_value       = cwnd_next;
        out_next.ssthresh_value   = ssthresh_next;
        out_next.slow_start_on    = slow_next;
        out_next.cong_avoid_on    = avoid_next;
        out_next.fast_recovery_on = recov_next;
        out_next.timeout_us       = rto_next;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_win_reg     <= RST_RECEIVE_WINDOW;
            avoid_ssth_reg   <= RST_AVOIDANCE_SSTHRESH;
            rto_cap_reg      <= RST_TIMEOUT_CAP;
            fallback_rto_reg <= RST_FALLBACK_TIMEOUT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RECEIVE_WINDOW:     recv_win_reg     <= cfg_data[15:0];
                REG_AVOIDANCE_SSTHRESH: avoid_ssth_reg   <= cfg_data[15:0];
                REG_TIMEOUT_CAP:        rto_cap_reg      <= cfg_data[23:0];
                REG_FALLBACK_TIMEOUT:   fallback_rto_reg <= cfg_data[23:0];
                default:                ;
            endcase
        end
    end

    // State registers. Writing an initial-value register also loads its state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_base_reg <= RST_INITIAL_SEND_BASE;
            dup_count_reg <= 2'd0;
            cwnd_reg      <= 16'd1;
            ssthresh_reg  <= RST_INITIAL_SSTHRESH;
            slow_reg      <= 1'b1;
            avoid_reg     <= 1'b0;
            recov_reg     <= 1'b0;
            srtt_reg      <= RST_INITIAL_SRTT;
            rtt_dev_reg   <= 24'd0;
            rto_reg       <= RST_INITIAL_TIMEOUT;
        end
        else
        begin
            if (advance)
            begin
                send_base_reg <= send_base_next;
                dup_count_reg <= dup_count_next;
                cwnd_reg      <= cwnd_next;
                ssthresh_reg  <= ssthresh_next;
                slow_reg      <= slow_next;
                avoid_reg     <= avoid_next;
                recov_reg     <= recov_next;
                srtt_reg      <= srtt_next;
                rtt_dev_reg   <= rtt_dev_next;
                rto_reg       <= rto_next;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_INITIAL_SSTHRESH:  ssthresh_reg  <= cfg_data[15:0];
                    REG_INITIAL_SRTT:      srtt_reg      <= cfg_data[23:0];
                    REG_INITIAL_TIMEOUT:   rto_reg       <= cfg_data[23:0];
                    REG_INITIAL_SEND_BASE: send_base_reg <= cfg_data;
                    default:               ;
                endcase
            end
        end
    end

endmodule

@@ src/rtcc_checker.sv @@
module rtcc_port_checker
    import rtcc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input rtcc_out_t out_data
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // The congestion window never reaches zero and caps the allowance.
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.cwnd_value != 16'd0
                      && out_data.window_limit <= out_data.cwnd_value)
        else $error("window limit or cwnd out of range");

    // A timeout restarts slow start from one segment.
    a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.resend_unacked |-> out_data.cwnd_value == 16'd1
            && out_data.slow_start_on && !out_data.cong_avoid_on
            && !out_data.fast_recovery_on && !out_data.fast_retransmit)
        else $error("timeout result inconsistent");

    // The retransmit sequence is only shown with a fast retransmit request.
    a_rtx_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.fast_retransmit |-> out_data.retransmit_seq == 32'd0)
        else $error("retransmit sequence without request");

endmodule

bind reliable_transport_congestion_control_unit rtcc_port_checker u_rtcc_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
